// ===== rtl/core/yuvcnv_pkg.sv =====
// types and constants for the planar 4:2:0 to packed 4:4:4 converter
// no dependencies; used by planar_yuv420_to_packed_yuv444_top
`timescale 1ns / 1ps
`default_nettype none

package yuvcnv_pkg;

  localparam int unsigned CfgWidth = 9;
  localparam int unsigned AddrWidth = 17;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  // request command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CfgWidth-1:0] FRAME_SIZE_RESET = 9'd256;

  typedef struct packed {
    logic                 cmd;
    logic [AddrWidth-1:0] write_address;
    logic [ByteWidth-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [ByteWidth-1:0] luma;
    logic [ByteWidth-1:0] chroma_first;
    logic [ByteWidth-1:0] chroma_second;
    logic                 last_pixel;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/planar_yuv420_to_packed_yuv444_top.sv =====
// a read request is accepted, then passes an address multiply stage, three reads of the one-port
// frame store and an output stage that waits for the output register to be free; no new request
// is accepted until it is done; one write request per cycle while no read is in progress
// reset: pixel counters go to zero, frame width and height to 256; the frame store
// is not cleared, so every byte must be written before a pixel that uses it is read
// depends on yuvcnv_pkg
`timescale 1ns / 1ps
`default_nettype none

module planar_yuv420_to_packed_yuv444_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // request channel
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  yuvcnv_pkg::req_t                      in_req_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output yuvcnv_pkg::rsp_t                      out_rsp_o,
  // configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [yuvcnv_pkg::ApbAddrWidth-1:0]   paddr,
  input  wire  [yuvcnv_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [yuvcnv_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                  pready
);
  import yuvcnv_pkg::*;

  localparam int unsigned Depth = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_RD_Y,
    ST_RD_U,
    ST_RD_V,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CfgWidth-1:0] width_q, height_q;
  logic [CW-1:0]       col_q;
  logic [RW-1:0]       row_q;

  logic [AW-1:0] luma_addr_q, frame_q, cpos_q, u_addr_q, v_addr_q;
  logic          last_q;
  logic [ByteWidth-1:0] luma_q, cb_q;
  logic          out_valid_q;
  rsp_t          out_q;

  // frame store
  logic [ByteWidth-1:0] mem [Depth];
  logic [ByteWidth-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr;
  logic [31:0]          waddr_full;

  // ---------------------------------------------------------------------------
  // configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_SIZE_RESET;
      height_q <= FRAME_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  width_q  <= pwdata[CfgWidth-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(ApbDataWidth-CfgWidth){1'b0}}, width_q};
      REG_FRAME_HEIGHT: prdata = {{(ApbDataWidth-CfgWidth){1'b0}}, height_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // effective frame size, zero counts as one, large values saturate
  logic [31:0] w_full, h_full;
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (width_q == '0) begin
      w_full = 32'd1;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(width_q);
    end
    if (height_q == '0) begin
      h_full = 32'd1;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(height_q);
    end
  end

  assign w = w_full[WW-1:0];
  assign h = h_full[HW-1:0];

  // ---------------------------------------------------------------------------
  // counter fixup on accept (frame may have shrunk) and advance after a pixel
  logic [RW:0]   row_t, row_inc;
  logic [CW-1:0] col_n;
  logic [RW-1:0] row_n;
  logic [CW:0]   col_adv;
  logic [RW:0]   row_adv;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  always_comb begin
    row_inc = {1'b0, row_q} + 1'b1;
    if (32'(col_q) >= 32'(w)) begin
      col_n = '0;
      row_t = row_inc;
    end else begin
      col_n = col_q;
      row_t = {1'b0, row_q};
    end
    if (32'(row_t) >= 32'(h)) begin
      row_n = '0;
    end else begin
      row_n = row_t[RW-1:0];
    end

    col_adv = {1'b0, col_q} + 1'b1;
    row_adv = {1'b0, row_q} + 1'b1;
    if (32'(col_adv) >= 32'(w)) begin
      col_next = '0;
      row_next = (32'(row_adv) >= 32'(h)) ? '0 : row_adv[RW-1:0];
    end else begin
      col_next = col_adv[CW-1:0];
      row_next = row_q;
    end
  end

  // ---------------------------------------------------------------------------
  // memory port control
  logic in_fire, out_free;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign waddr_full = 32'(in_req_i.write_address);

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = waddr_full[AW-1:0];
    unique case (state_q)
      ST_IDLE: mem_we = in_fire && (in_req_i.cmd == CMD_WRITE)
                        && (waddr_full < 32'(Depth));
      ST_RD_Y: begin
        mem_re   = 1'b1;
        mem_addr = luma_addr_q;
      end
      ST_RD_U: begin
        mem_re   = 1'b1;
        mem_addr = u_addr_q;
      end
      ST_RD_V: begin
        mem_re   = 1'b1;
        mem_addr = v_addr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= in_req_i.write_data;
    end else if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      luma_addr_q <= '0;
      frame_q     <= '0;
      cpos_q      <= '0;
      u_addr_q    <= '0;
      v_addr_q    <= '0;
      last_q      <= 1'b0;
      luma_q      <= '0;
      cb_q        <= '0;
      out_q       <= '0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_req_i.cmd == CMD_READ)) begin
            col_q   <= col_n;
            row_q   <= row_n;
            state_q <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          luma_addr_q <= AW'(AW'(row_q) * AW'(w) + AW'(col_q));
          frame_q     <= AW'(AW'(w) * AW'(h));
          cpos_q      <= AW'(AW'(row_q >> 1) * AW'(w >> 1) + AW'(col_q >> 1));
          last_q      <= (32'(row_q) + 32'd1 == 32'(h)) && (32'(col_q) + 32'd1 == 32'(w));
          state_q     <= ST_RD_Y;
        end
        ST_RD_Y: begin
          u_addr_q <= frame_q + cpos_q;
          state_q  <= ST_RD_U;
        end
        ST_RD_U: begin
          luma_q   <= rdata_q;
          v_addr_q <= u_addr_q + (frame_q >> 2);
          state_q  <= ST_RD_V;
        end
        ST_RD_V: begin
          cb_q    <= rdata_q;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_q.luma          <= luma_q;
            out_q.chroma_first  <= cb_q;
            out_q.chroma_second <= rdata_q;
            out_q.last_pixel    <= last_q;
            col_q               <= col_next;
            row_q               <= row_next;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire
